/* design/bitmap_first_free_allocator_assert.svh */
// assertion macros for the bitmap first-free allocator checker
// used by bffa_checker.sv; no other dependencies
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFFA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bffa assertion failed");

// next-cycle implication
`define BFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bffa assertion failed");

`endif

/* design/bffa_pkg.sv */
// shared types and constants for the bitmap first-free allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

   localparam int NUM_ENTRIES = 1024;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int NUM_WORDS   = NUM_ENTRIES / WORD_W;
   localparam int WADDR_W     = $clog2(NUM_WORDS);
   localparam int ENTRY_W     = 11;
   localparam int LIMW_W      = ENTRY_W - BIT_W;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam logic [ENTRY_W-1:0] LIMIT_RESET = 11'd1024;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOTALLOC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ALLOC_HIT,
      OP_ALLOC_FULL,
      OP_FREE_HIT,
      OP_FREE_MISS,
      OP_RANGE
   } op_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SCAN_FIRST,
      CS_SCAN,
      CS_FREE_RD,
      CS_FREE_CHK,
      CS_DONE
   } ctl_state_type;

   typedef struct packed {
      logic   accept;
      logic   scan_rd;
      logic   free_rd;
      op_type op;
      logic   rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic lim_zero;
      logic range_err;
      logic hit;
      logic last_word;
      logic bit_set;
   } dp_status_type;

endpackage

`default_nettype wire

/* design/bitmap_first_free_allocator.sv */
// top level of the bitmap first-free allocator
// depends on bffa_pkg, bffa_ctrl and bffa_dpath
//
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   tdata: entry_number; tuser: req_type
// rsp       out  rsp_tvalid/rsp_tready   tdata: granted_entry, free_count; tuser: status
// csr       in   csr_wr_en               csr_wr_data: entry_limit
//
// allocate: scans the bitmap from word 0 up to the word of the last entry below the limit
//   and stops at the first free bit, one 32-bit word per cycle from the single ram read port
// free: one ram read, plus one ram write if the entry is allocated; none when out of range
// reset clears the bitmap at once through per-word valid flags, no clearing pass
// a new request is taken while the previous result waits in the output register
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_free_allocator import bffa_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [ENTRY_W-1:0]     csr_wr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,    // entry_number[10:0]
   input  wire logic                   req_tuser,    // req_type[0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,    // granted_entry[10:0], free_count[21:11]
   output logic [1:0]                  rsp_tuser     // status[1:0]
);

   dp_cmd_type         dp_cmd;
   dp_status_type      dp_st;
   logic [ENTRY_W-1:0] rsp_granted;
   status_type         rsp_status;
   logic [ENTRY_W-1:0] rsp_free_count;

   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_st      (dp_st),
      .dp_cmd     (dp_cmd)
   );

   bffa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_number     (req_tdata[ENTRY_W-1:0]),
      .dp_cmd         (dp_cmd),
      .dp_st          (dp_st),
      .rsp_granted    (rsp_granted),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_free_count, rsp_granted});
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

/* design/bffa_ctrl.sv */
// controller state machine of the bitmap first-free allocator
// depends on bffa_pkg; drives the datapath through dp_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module bffa_ctrl import bffa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire req_kind_type  req_kind,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type dp_st,
   output dp_cmd_type         dp_cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      dp_cmd       = '0;
      dp_cmd.op    = OP_NONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.accept = 1'b1;
               state_in = (req_kind == REQ_ALLOC) ? CS_SCAN_FIRST : CS_FREE_RD;
            end
         end
         CS_SCAN_FIRST: begin
            if (dp_st.lim_zero) begin
               dp_cmd.op = OP_ALLOC_FULL;
               state_in  = CS_DONE;
            end else begin
               dp_cmd.scan_rd = 1'b1;
               state_in       = CS_SCAN;
            end
         end
         CS_SCAN: begin
            if (dp_st.hit) begin
               dp_cmd.op = OP_ALLOC_HIT;
               state_in  = CS_DONE;
            end else if (dp_st.last_word) begin
               dp_cmd.op = OP_ALLOC_FULL;
               state_in  = CS_DONE;
            end else begin
               dp_cmd.scan_rd = 1'b1;
            end
         end
         CS_FREE_RD: begin
            if (dp_st.range_err) begin
               dp_cmd.op = OP_RANGE;
               state_in  = CS_DONE;
            end else begin
               dp_cmd.free_rd = 1'b1;
               state_in       = CS_FREE_CHK;
            end
         end
         CS_FREE_CHK: begin
            dp_cmd.op = dp_st.bit_set ? OP_FREE_HIT : OP_FREE_MISS;
            state_in  = CS_DONE;
         end
         CS_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.rsp_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == CS_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/bffa_dpath.sv */
// datapath of the bitmap first-free allocator: bitmap ram, scan, counters, result
// depends on bffa_pkg; commanded by bffa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module bffa_dpath import bffa_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [ENTRY_W-1:0] csr_wr_data,
   input  wire logic [ENTRY_W-1:0] req_number,
   input  wire dp_cmd_type         dp_cmd,
   output dp_status_type           dp_st,
   output logic [ENTRY_W-1:0]      rsp_granted,
   output status_type              rsp_status,
   output logic [ENTRY_W-1:0]      rsp_free_count
);

   logic [WORD_W-1:0]  bitmap_mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] row_valid_ff;

   logic [ENTRY_W-1:0] limit_ff;
   logic [ENTRY_W-1:0] lim_ff;
   logic [ENTRY_W-1:0] num_ff;
   logic [ENTRY_W-1:0] used_ff, used_in;
   logic [WADDR_W-1:0] scan_addr_ff;
   logic [WADDR_W-1:0] chk_addr_ff;
   logic [WORD_W-1:0]  rd_word_ff;
   logic               rd_vld_ff;
   logic [ENTRY_W-1:0] gnt_ff, gnt_in;
   status_type         stat_ff, stat_in;
   logic [ENTRY_W-1:0] rsp_granted_ff;
   status_type         rsp_status_ff;
   logic [ENTRY_W-1:0] rsp_free_ff;

   logic [ENTRY_W-1:0] lim_cap;
   logic [WORD_W-1:0]  word_eff;
   logic [WORD_W-1:0]  beyond_mask;
   logic [WORD_W-1:0]  free_vec;
   logic [BIT_W-1:0]   hit_bit;
   logic [LIMW_W-1:0]  chk_ext;
   logic [ENTRY_W-1:0] lim_m1;
   logic [ENTRY_W-1:0] free_idx;
   logic [WADDR_W-1:0] free_word;
   logic [BIT_W-1:0]   free_bit;
   logic [WADDR_W-1:0] rd_addr;
   logic               wr_en;
   logic [WADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0]  wr_data;

   assign lim_cap = (32'(limit_ff) > NUM_ENTRIES) ? ENTRY_W'(NUM_ENTRIES) : limit_ff;

   // bitmap word as read, zero for rows not written since reset
   assign word_eff = rd_vld_ff ? rd_word_ff : '0;
   assign chk_ext  = LIMW_W'(chk_addr_ff);
   assign lim_m1   = lim_ff - ENTRY_W'(1);

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         if (chk_ext > lim_ff[ENTRY_W-1:BIT_W]) begin
            beyond_mask[b] = 1'b1;
         end else if (chk_ext == lim_ff[ENTRY_W-1:BIT_W]) begin
            beyond_mask[b] = (BIT_W'(b) >= lim_ff[BIT_W-1:0]);
         end else begin
            beyond_mask[b] = 1'b0;
         end
      end
   end

   assign free_vec = ~(word_eff | beyond_mask);

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign free_idx  = num_ff - ENTRY_W'(1);
   assign free_word = free_idx[BIT_W +: WADDR_W];
   assign free_bit  = free_idx[BIT_W-1:0];

   assign dp_st.lim_zero  = (lim_ff == '0);
   assign dp_st.range_err = (num_ff == '0) || (num_ff > lim_ff);
   assign dp_st.hit       = |free_vec;
   assign dp_st.last_word = (chk_ext == lim_m1[ENTRY_W-1:BIT_W]);
   assign dp_st.bit_set   = word_eff[free_bit];

   assign rd_addr = dp_cmd.free_rd ? free_word : scan_addr_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_addr_ff;
      wr_data = word_eff;
      used_in = used_ff;
      gnt_in  = gnt_ff;
      stat_in = stat_ff;
      case (dp_cmd.op)
         OP_ALLOC_HIT: begin
            wr_en   = 1'b1;
            wr_data = word_eff | (WORD_W'(1) << hit_bit);
            used_in = used_ff + ENTRY_W'(1);
            gnt_in  = ENTRY_W'({chk_addr_ff, hit_bit}) + ENTRY_W'(1);
            stat_in = STATUS_OK;
         end
         OP_ALLOC_FULL: begin
            gnt_in  = '0;
            stat_in = STATUS_FULL;
         end
         OP_FREE_HIT: begin
            wr_en   = 1'b1;
            wr_addr = free_word;
            wr_data = word_eff & ~(WORD_W'(1) << free_bit);
            used_in = (used_ff != '0) ? used_ff - ENTRY_W'(1) : used_ff;
            gnt_in  = '0;
            stat_in = STATUS_OK;
         end
         OP_FREE_MISS: begin
            gnt_in  = '0;
            stat_in = STATUS_NOTALLOC;
         end
         OP_RANGE: begin
            gnt_in  = '0;
            stat_in = STATUS_RANGE;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // bitmap ram, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= bitmap_mem[rd_addr];
      rd_vld_ff  <= row_valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         limit_ff     <= LIMIT_RESET;
         used_ff      <= '0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      gnt_ff  <= gnt_in;
      stat_ff <= stat_in;
      if (dp_cmd.accept) begin
         lim_ff       <= lim_cap;
         num_ff       <= req_number;
         scan_addr_ff <= '0;
      end else if (dp_cmd.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + WADDR_W'(1);
      end
      if (dp_cmd.scan_rd) begin
         chk_addr_ff <= scan_addr_ff;
      end
      if (dp_cmd.rsp_load) begin
         rsp_granted_ff <= gnt_ff;
         rsp_status_ff  <= stat_ff;
         rsp_free_ff    <= (lim_ff > used_ff) ? lim_ff - used_ff : '0;
      end
   end

   assign rsp_granted    = rsp_granted_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

`default_nettype wire

/* design/bffa_checker.sv */
// port-level checker for the bitmap first-free allocator, bound to the top level
// depends on bffa_pkg and bitmap_first_free_allocator_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_first_free_allocator_assert.svh"

module bffa_checker import bffa_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]             rsp_tuser
);

   logic [ENTRY_W-1:0] granted;
   logic [ENTRY_W-1:0] free_cnt;

   assign granted  = rsp_tdata[ENTRY_W-1:0];
   assign free_cnt = rsp_tdata[2*ENTRY_W-1:ENTRY_W];

   // a full answer grants nothing and leaves nothing free
   `BFFA_ASSERT_NOW(a_full_empty, clock, reset,
      rsp_tvalid && (rsp_tuser == STATUS_FULL), (granted == '0) && (free_cnt == '0))
   // a granted entry only comes with an ok status and within the entry count
   `BFFA_ASSERT_NOW(a_grant_ok, clock, reset,
      rsp_tvalid && (granted != '0), (rsp_tuser == STATUS_OK) && (32'(granted) <= NUM_ENTRIES))
   // a stalled transfer keeps valid
   `BFFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // a stalled transfer keeps its payload
   `BFFA_ASSERT_NEXT(a_rsp_stable, clock, reset,
      rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   // requests are taken one transfer at a time
   `BFFA_ASSERT_NEXT(a_req_single, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* dv/bitmap_first_free_allocator_tb.sv */
// self-checking testbench for bitmap_first_free_allocator: allocate and free transfers
// are predicted against an in-bench bitmap and compared field by field with each response
// depends on bffa_pkg and the allocator rtl
`timescale 1ns / 1ps

module bitmap_first_free_allocator_tb;
   import bffa_pkg::*;

   localparam int IDLE_MAX       = 12;
   localparam int QUIET_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 750;
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

   typedef struct packed {
      logic [ENTRY_W-1:0] granted;
      status_type         status;
      logic [ENTRY_W-1:0] free_count;
   } alloc_answer_t;

   typedef struct {
      bit                 is_limit;
      req_kind_type       kind;
      logic [ENTRY_W-1:0] number;
      int                 gap;
   } request_item_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [ENTRY_W-1:0]     csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   // bitmap shadow and allocation state
   bit [NUM_ENTRIES-1:0]   alloc_map;
   int                     used_entries;
   logic [ENTRY_W-1:0]     entry_limit_reg;

   request_item_t          request_q[$];
   alloc_answer_t          answer_q[$];
   int                     error_count = 0;
   int                     quiet_cycles = 0;
   int                     issued = 0;
   bit                     req_taken = 1'b0;
   bit                     rsp_taken = 1'b0;
   int                     send_idle = 0;
   int                     rsp_hold = 0;
   bit                     send_calm = 1'b0;
   bit                     recv_calm = 1'b0;

   bitmap_first_free_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // idle count per transfer, with stretches of back-to-back traffic
   function automatic int next_idle(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   function automatic int capped_limit(logic [ENTRY_W-1:0] lim);
      return (lim > NUM_ENTRIES) ? NUM_ENTRIES : int'(lim);
   endfunction

   // first-fit allocate or free against the shadow bitmap
   function automatic alloc_answer_t apply_request(req_kind_type kind,
                                                   logic [ENTRY_W-1:0] number);
      alloc_answer_t ans;
      int            lim;
      bit            found;
      lim        = capped_limit(entry_limit_reg);
      found      = 1'b0;
      ans.granted = '0;
      ans.status  = STATUS_OK;
      if (kind == REQ_ALLOC) begin
         ans.status = STATUS_FULL;
         for (int i = 0; i < lim && !found; i++) begin
            if (!alloc_map[i]) begin
               alloc_map[i] = 1'b1;
               used_entries++;
               ans.granted = ENTRY_W'(i + 1);
               ans.status  = STATUS_OK;
               found       = 1'b1;
            end
         end
      end else if (number == 0 || number > lim) begin
         ans.status = STATUS_RANGE;
      end else if (!alloc_map[number - 1]) begin
         ans.status = STATUS_NOTALLOC;
      end else begin
         alloc_map[number - 1] = 1'b0;
         if (used_entries > 0) used_entries--;
      end
      ans.free_count = (lim > used_entries) ? ENTRY_W'(lim - used_entries) : '0;
      return ans;
   endfunction

   task automatic push_req(req_kind_type kind, logic [ENTRY_W-1:0] number);
      request_item_t item;
      item.is_limit = 1'b0;
      item.kind     = kind;
      item.number   = number;
      item.gap      = next_idle(send_calm);
      request_q.push_back(item);
      issued++;
   endtask

   task automatic push_limit(logic [ENTRY_W-1:0] value);
      request_item_t item;
      item.is_limit = 1'b1;
      item.kind     = REQ_ALLOC;
      item.number   = value;
      item.gap      = 0;
      request_q.push_back(item);
   endtask

   // request driver: presents queued transfers, limit writes only when nothing is outstanding
   always @(negedge clock) begin : drive_requests
      logic v_next;
      logic w_next;
      v_next = req_tvalid;
      w_next = 1'b0;
      if (!reset) begin
         if (req_taken) begin
            v_next    = 1'b0;
            req_taken = 1'b0;
         end
         if (!v_next && request_q.size() != 0) begin
            if (request_q[0].is_limit) begin
               if (answer_q.size() == 0) begin
                  w_next = 1'b1;
                  csr_wr_data <= request_q[0].number;
                  void'(request_q.pop_front());
               end
            end else if (send_idle < request_q[0].gap) begin
               send_idle++;
            end else begin
               v_next = 1'b1;
               req_tdata <= REQ_TDATA_W'(request_q[0].number);
               req_tuser <= request_q[0].kind;
               void'(request_q.pop_front());
               send_idle = 0;
            end
         end
      end
      req_tvalid <= v_next;
      csr_wr_en  <= w_next;
   end

   // response backpressure
   always @(negedge clock) begin : drive_rsp_ready
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_hold  = next_idle(recv_calm);
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predicts on request transfer, checks on response transfer
   always @(posedge clock) begin : track_transfers
      alloc_answer_t want;
      logic [ENTRY_W-1:0] got_granted;
      logic [ENTRY_W-1:0] got_free;
      if (reset) begin
         alloc_map       = '0;
         used_entries    = 0;
         entry_limit_reg = LIMIT_RESET;
         quiet_cycles    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken   = 1'b1;
            got_granted = rsp_tdata[ENTRY_W-1:0];
            got_free    = rsp_tdata[2*ENTRY_W-1:ENTRY_W];
            if (answer_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response granted_entry %0d status %0d free_count %0d",
                        $time, got_granted, rsp_tuser, got_free);
            end else begin
               want = answer_q.pop_front();
               if (got_granted !== want.granted) begin
                  error_count++;
                  $display("%0t: granted_entry expected %0d got %0d",
                           $time, want.granted, got_granted);
               end
               if (rsp_tuser !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
               end
               if (got_free !== want.free_count) begin
                  error_count++;
                  $display("%0t: free_count expected %0d got %0d",
                           $time, want.free_count, got_free);
               end
            end
         end
         if (csr_wr_en) entry_limit_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            answer_q.push_back(apply_request(req_kind_type'(req_tuser),
                                             req_tdata[ENTRY_W-1:0]));
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bitmap_first_free_allocator_tb: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int lim_pick;
      int eff;
      int n_ops;
      bit fill;
      int r;

      // range errors, first-fit order, double free
      push_req(REQ_FREE, 11'd0);
      push_req(REQ_FREE, 11'd1025);
      push_req(REQ_FREE, ENTRY_MAX);
      push_req(REQ_FREE, 11'd5);
      push_req(REQ_ALLOC, ENTRY_MAX);
      push_req(REQ_ALLOC, 11'd0);
      push_req(REQ_ALLOC, 11'h555);
      push_req(REQ_FREE, 11'd2);
      push_req(REQ_FREE, 11'd2);
      push_req(REQ_ALLOC, 11'h2AA);
      // zero limit
      push_limit(11'd0);
      push_req(REQ_ALLOC, 11'd0);
      push_req(REQ_FREE, 11'd1);
      // limit above the bitmap size saturates
      push_limit(ENTRY_MAX);
      push_req(REQ_FREE, 11'd1024);
      push_req(REQ_ALLOC, 11'd0);
      // limit lowered below allocated entries
      push_limit(11'd3);
      push_req(REQ_ALLOC, 11'd0);
      push_req(REQ_FREE, 11'd4);
      push_req(REQ_FREE, 11'd3);
      push_req(REQ_ALLOC, 11'd0);
      push_limit(11'd1);
      push_req(REQ_ALLOC, 11'd0);
      push_req(REQ_FREE, 11'd1);
      push_req(REQ_ALLOC, 11'd0);
      push_limit(LIMIT_RESET);
      push_req(REQ_FREE, 11'd1024);
      push_req(REQ_FREE, 11'd4);

      while (issued < RANDOM_ITEMS) begin
         lim_pick = $urandom_range(0, 19);
         case (lim_pick)
            0:       eff = 0;
            1:       eff = NUM_ENTRIES;
            2:       eff = $urandom_range(NUM_ENTRIES + 1, 2047);
            3:       eff = $urandom_range(65, NUM_ENTRIES - 1);
            default: eff = $urandom_range(1, 64);
         endcase
         push_limit(ENTRY_W'(eff));
         if (eff > NUM_ENTRIES) eff = NUM_ENTRIES;
         fill  = $urandom_range(0, 1);
         n_ops = $urandom_range(15, 50);
         repeat (n_ops) begin
            if ($urandom_range(0, 9) < (fill ? 8 : 2)) begin
               push_req(REQ_ALLOC, ENTRY_W'($urandom_range(0, 2047)));
            end else begin
               r = $urandom_range(0, 9);
               if (r < 7)
                  push_req(REQ_FREE, ENTRY_W'((eff == 0) ? 0 :
                                              $urandom_range(1, (eff < 48) ? eff : 48)));
               else if (r < 9)
                  push_req(REQ_FREE, ENTRY_W'($urandom_range(0, eff + 2)));
               else
                  push_req(REQ_FREE, ENTRY_W'($urandom_range(0, 2047)));
            end
         end
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || answer_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && answer_q.size() == 0)
         $display("bitmap_first_free_allocator_tb: clean");
      else
         $display("bitmap_first_free_allocator_tb: errors");
      $finish;
   end

endmodule
